/* sv/crm_pkg.sv */
package crm_pkg;

	localparam int POS_W  = 11;
	localparam int DATA_W = 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_ADD   = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [9:0]         left_index;
		logic [9:0]         right_index;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic signed [63:0] min_value;
		logic               index_error;
	} rsp_t;

	// one tree walk over [st, en]
	typedef struct packed {
		logic                     go;
		logic [1:0]               op;
		logic                     first;
		logic [POS_W-1:0]         st;
		logic [POS_W-1:0]         en;
		logic [POS_W-1:0]         last;
		logic signed [DATA_W-1:0] data;
	} wk_job_t;

	typedef struct packed {
		logic                     ready;
		logic                     done;
		logic signed [DATA_W-1:0] best;
	} wk_stat_t;

endpackage

/* sv/circular_range_add_range_min_core.sv */
// Circular range add / range minimum over up to MAX_ELEMENTS signed 64-bit
// elements held in a lazy min segment tree. Tree minima and pending adds live
// in two single-port-read, single-port-write RAMs of 2**($clog2(MAX_ELEMENTS)+1)
// words; after reset the pending-add RAM is cleared with req_stall high.
// Items are handled one at a time by a stack-driven tree walker. A node
// that lies outside the range is skipped, a covered node is added to or
// read, and a partly covered node first pushes down any pending add; an add
// or a load then pulls the minimum up again. A range that wraps is walked
// in two parts. Errors skip the walk and ignored types return to idle.
// array_size must only change while idle.
module circular_range_add_range_min_core #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crm_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data
);

	localparam int NODE_W = $clog2(MAX_ELEMENTS) + 1;
	localparam int POS_W  = crm_pkg::POS_W;

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_CHK  = 3'd1;
	localparam logic [2:0] T_RUN1 = 3'd2;
	localparam logic [2:0] T_RUN2 = 3'd3;
	localparam logic [2:0] T_RES  = 3'd4;

	logic [2:0]        state_q;
	logic [10:0]       array_size_q;
	crm_pkg::req_t     req_q;
	logic              wrap_q, err_q;
	crm_pkg::wk_job_t  job_q;
	crm_pkg::wk_stat_t wk_st;
	crm_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	logic [POS_W-1:0]  n_eff, lz, rz;
	logic              err, wrap, is_load;
	logic              op_ok, go_first, go_second;
	logic signed [63:0] d64;

	assign n_eff   = (32'(array_size_q) > MAX_ELEMENTS) ? POS_W'(MAX_ELEMENTS) : array_size_q;
	assign lz      = POS_W'(req_q.left_index);
	assign rz      = POS_W'(req_q.right_index);
	assign is_load = (req_q.req_type == crm_pkg::OP_LOAD);
	assign err     = (lz >= n_eff) || (!is_load && rz >= n_eff);
	assign wrap    = !is_load && (lz > rz);
	assign d64     = {{32{req_q.data_value[31]}}, req_q.data_value};
	assign op_ok   = (req_q.req_type == crm_pkg::OP_LOAD) || (req_q.req_type == crm_pkg::OP_QUERY)
			|| (req_q.req_type == crm_pkg::OP_ADD);

	assign go_first  = (state_q == T_CHK) && op_ok && !err;
	assign go_second = (state_q == T_RUN1) && wk_st.done && wrap_q;

	crm_walk #(.NODE_W(NODE_W)) u_walk (
		.clk(clk), .arst_n(arst_n), .job(job_q), .stat(wk_st)
	);

	assign req_stall = !((state_q == T_IDLE) && wk_st.ready);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			array_size_q <= 11'd1024;
			job_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			job_q.go <= go_first || go_second;
			if (cfg_valid && cfg_ready) begin
				array_size_q <= cfg_data;
			end
			if (state_q == T_RES && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (req_valid && !req_stall) begin
						state_q <= T_CHK;
					end
				end
				T_CHK: begin
					if (!op_ok) begin
						state_q <= T_IDLE;
					end else if (err) begin
						state_q <= T_RES;
					end else begin
						job_q.op    <= req_q.req_type;
						job_q.first <= 1'b1;
						job_q.st    <= lz;
						job_q.en    <= is_load ? lz : (wrap ? n_eff - 1'b1 : rz);
						job_q.last  <= n_eff - 1'b1;
						job_q.data  <= d64;
						state_q     <= T_RUN1;
					end
				end
				T_RUN1: begin
					if (wk_st.done) begin
						if (wrap_q) begin
							job_q.first <= 1'b0;
							job_q.st    <= '0;
							job_q.en    <= rz;
							state_q     <= T_RUN2;
						end else begin
							state_q <= (req_q.req_type == crm_pkg::OP_QUERY) ? T_RES : T_IDLE;
						end
					end
				end
				T_RUN2: begin
					if (wk_st.done) begin
						state_q <= (req_q.req_type == crm_pkg::OP_QUERY) ? T_RES : T_IDLE;
					end
				end
				T_RES: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && req_valid && !req_stall) begin
			req_q <= req;
		end
		if (state_q == T_CHK) begin
			wrap_q <= wrap;
			err_q  <= err;
		end
		if (state_q == T_RES && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.min_value   <= err_q ? '0 : wk_st.best;
			rsp_q.index_error <= err_q;
		end
	end

`ifndef SYNTHESIS
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		wk_st.done |-> (state_q == T_RUN1 || state_q == T_RUN2))
		else $error("walker done outside a run");
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == T_CHK))
		else $error("accepted beat not checked");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.index_error) |-> (rsp.min_value == '0))
		else $error("error beat with nonzero value");
`endif

endmodule

/* sv/crm_ram.sv */
module crm_ram #(
	parameter int AW = 11,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/crm_walk.sv */
module crm_walk #(
	parameter int NODE_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crm_pkg::wk_job_t  job,
	output crm_pkg::wk_stat_t stat
);

	localparam int POS_W = crm_pkg::POS_W;
	localparam int DW    = crm_pkg::DATA_W;
	localparam int STK_D = 2 * NODE_W + 2;
	localparam int SP_W  = $clog2(STK_D + 1);
	localparam int IX_W  = $clog2(STK_D);

	localparam logic [3:0] W_CLR  = 4'd0;
	localparam logic [3:0] W_IDLE = 4'd1;
	localparam logic [3:0] W_POP  = 4'd2;
	localparam logic [3:0] W_EVAL = 4'd3;
	localparam logic [3:0] W_COV  = 4'd4;
	localparam logic [3:0] W_QRY  = 4'd5;
	localparam logic [3:0] W_PD1  = 4'd6;
	localparam logic [3:0] W_PD2  = 4'd7;
	localparam logic [3:0] W_PD3  = 4'd8;
	localparam logic [3:0] W_PD4  = 4'd9;
	localparam logic [3:0] W_PUSH = 4'd10;
	localparam logic [3:0] W_PU1  = 4'd11;
	localparam logic [3:0] W_PU2  = 4'd12;

	logic [3:0]        state_q;
	logic [SP_W-1:0]   sp_q;
	logic [NODE_W-1:0] stk_node [STK_D];
	logic [POS_W-1:0]  stk_lo   [STK_D];
	logic [POS_W-1:0]  stk_hi   [STK_D];
	logic              stk_pull [STK_D];
	logic [NODE_W-1:0] node_q;
	logic [POS_W-1:0]  lo_q, hi_q;
	logic              pull_q;
	crm_pkg::wk_job_t  job_q;
	logic [DW-1:0]     p_q, tmp_q;
	logic signed [DW-1:0] best_q;
	logic              found_q;
	logic [NODE_W-1:0] clr_q;

	logic              nm_we, pa_we;
	logic [NODE_W-1:0] nm_wa, pa_wa, nm_ra, pa_ra;
	logic [DW-1:0]     nm_wd, pa_wd, nm_rd, pa_rd;

	logic [NODE_W-1:0] c0, c1;
	logic [POS_W-1:0]  mid;
	logic [IX_W-1:0]   top_ix, ix0, ix1, ix2;
	logic              outside, covered, leaf;

	assign c0      = {node_q[NODE_W-2:0], 1'b0};
	assign c1      = {node_q[NODE_W-2:0], 1'b1};
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign top_ix  = IX_W'(sp_q - 1'b1);
	assign ix0     = IX_W'(sp_q);
	assign ix1     = IX_W'(sp_q + 1'b1);
	assign ix2     = IX_W'(sp_q + 2'd2);
	assign outside = (hi_q < job_q.st) || (lo_q > job_q.en);
	assign covered = (job_q.st <= lo_q) && (hi_q <= job_q.en);
	assign leaf    = (lo_q == hi_q);

	crm_ram #(.AW(NODE_W), .DW(DW)) u_nm (
		.clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd)
	);

	crm_ram #(.AW(NODE_W), .DW(DW)) u_pa (
		.clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd)
	);

	always_comb begin
		nm_we = 1'b0;
		pa_we = 1'b0;
		nm_wa = node_q;
		pa_wa = node_q;
		nm_wd = nm_rd + p_q;
		pa_wd = pa_rd + p_q;
		nm_ra = node_q;
		pa_ra = node_q;
		unique case (state_q)
			W_CLR: begin
				pa_we = 1'b1;
				pa_wa = clr_q;
				pa_wd = '0;
			end
			W_EVAL: begin
				if (pull_q) begin
					nm_ra = c0;
				end else if (job_q.op == crm_pkg::OP_LOAD && leaf) begin
					nm_we = 1'b1;
					nm_wd = job_q.data;
				end
			end
			W_COV: begin
				nm_we = 1'b1;
				pa_we = 1'b1;
				nm_wd = nm_rd + job_q.data;
				pa_wd = pa_rd + job_q.data;
			end
			W_PD1: begin
				nm_ra = c0;
				pa_ra = c0;
			end
			W_PD2: begin
				nm_we = 1'b1;
				pa_we = 1'b1;
				nm_wa = c0;
				pa_wa = c0;
				nm_ra = c1;
				pa_ra = c1;
			end
			W_PD3: begin
				nm_we = 1'b1;
				pa_we = 1'b1;
				nm_wa = c1;
				pa_wa = c1;
			end
			W_PD4: begin
				pa_we = 1'b1;
				pa_wd = '0;
			end
			W_PU1: begin
				nm_ra = c1;
			end
			W_PU2: begin
				nm_we = 1'b1;
				nm_wd = ($signed(nm_rd) < $signed(tmp_q)) ? nm_rd : tmp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLR;
			sp_q    <= '0;
			clr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				W_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= W_IDLE;
					end
				end
				W_IDLE: begin
					if (job.go) begin
						sp_q    <= SP_W'(1);
						if (job.first) begin
							found_q <= 1'b0;
						end
						state_q <= W_POP;
					end
				end
				W_POP: begin
					if (sp_q == '0) begin
						state_q <= W_IDLE;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= W_EVAL;
					end
				end
				W_EVAL: begin
					if (pull_q) begin
						state_q <= W_PU1;
					end else if (job_q.op == crm_pkg::OP_LOAD) begin
						state_q <= leaf ? W_POP : W_PD1;
					end else if (outside) begin
						state_q <= W_POP;
					end else if (covered) begin
						state_q <= (job_q.op == crm_pkg::OP_ADD) ? W_COV : W_QRY;
					end else begin
						state_q <= W_PD1;
					end
				end
				W_COV: state_q <= W_POP;
				W_QRY: begin
					found_q <= 1'b1;
					state_q <= W_POP;
				end
				W_PD1: state_q <= (pa_rd == '0) ? W_PUSH : W_PD2;
				W_PD2: state_q <= W_PD3;
				W_PD3: state_q <= W_PD4;
				W_PD4: state_q <= W_PUSH;
				W_PUSH: begin
					sp_q    <= (job_q.op == crm_pkg::OP_ADD) ? sp_q + 2'd3 : sp_q + 2'd2;
					state_q <= W_POP;
				end
				W_PU1: state_q <= W_PU2;
				W_PU2: state_q <= W_POP;
				default: state_q <= W_IDLE;
			endcase
		end
	end

	// payload and walk stack
	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				if (job.go) begin
					job_q       <= job;
					stk_node[0] <= NODE_W'(1);
					stk_lo[0]   <= '0;
					stk_hi[0]   <= job.last;
					stk_pull[0] <= 1'b0;
				end
			end
			W_POP: begin
				node_q <= stk_node[top_ix];
				lo_q   <= stk_lo[top_ix];
				hi_q   <= stk_hi[top_ix];
				pull_q <= stk_pull[top_ix];
			end
			W_QRY: begin
				if (!found_q || ($signed(nm_rd) < best_q)) begin
					best_q <= nm_rd;
				end
			end
			W_PD1: p_q <= pa_rd;
			W_PUSH: begin
				if (job_q.op == crm_pkg::OP_QUERY) begin
					stk_node[ix0] <= c1;
					stk_lo[ix0]   <= mid + 1'b1;
					stk_hi[ix0]   <= hi_q;
					stk_pull[ix0] <= 1'b0;
					stk_node[ix1] <= c0;
					stk_lo[ix1]   <= lo_q;
					stk_hi[ix1]   <= mid;
					stk_pull[ix1] <= 1'b0;
				end else begin
					stk_node[ix0] <= node_q;
					stk_lo[ix0]   <= lo_q;
					stk_hi[ix0]   <= hi_q;
					stk_pull[ix0] <= 1'b1;
					if (job_q.op == crm_pkg::OP_LOAD) begin
						stk_node[ix1] <= (job_q.st <= mid) ? c0 : c1;
						stk_lo[ix1]   <= (job_q.st <= mid) ? lo_q : mid + 1'b1;
						stk_hi[ix1]   <= (job_q.st <= mid) ? mid : hi_q;
						stk_pull[ix1] <= 1'b0;
					end else begin
						stk_node[ix1] <= c1;
						stk_lo[ix1]   <= mid + 1'b1;
						stk_hi[ix1]   <= hi_q;
						stk_pull[ix1] <= 1'b0;
						stk_node[ix2] <= c0;
						stk_lo[ix2]   <= lo_q;
						stk_hi[ix2]   <= mid;
						stk_pull[ix2] <= 1'b0;
					end
				end
			end
			W_PU1: tmp_q <= nm_rd;
			default: begin
			end
		endcase
	end

	assign stat.ready = (state_q != W_CLR);
	assign stat.done  = (state_q == W_POP) && (sp_q == '0);
	assign stat.best  = best_q;

endmodule

/* sim/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 4096;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	crm_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	crm_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [10:0]   cfg_data = '0;

	circular_range_add_range_min_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the tree
	bit [63:0] tree_min [NODES];
	bit [63:0] tree_lazy [NODES];
	bit [10:0] size_reg = 11'd1024;

	crm_pkg::req_t pending_q [$];
	crm_pkg::rsp_t expected_q [$];
	int    errors = 0;
	int    n_queries = 0, n_adds = 0, n_loads = 0, n_oob = 0, n_rsp = 0;
	bit    beat_taken = 0;
	int    gap_left = 0, burst_left = 4;
	bit    long_hold_req = 0;
	int    hold_left = 0, mode_left = 0, stall_mode = 0;

	function automatic void put_item(crm_pkg::req_t it);
		pending_q = {pending_q, it};
	endfunction

	function automatic bit [63:0] smin(bit [63:0] a, bit [63:0] b);
		return ($signed(b) < $signed(a)) ? b : a;
	endfunction

	function automatic void push_lazy(int unsigned nd);
		int unsigned c;
		c = 2 * nd;
		if (c + 1 >= NODES) return;
		if (tree_lazy[nd] != 0) begin
			tree_min[c] += tree_lazy[nd];
			tree_lazy[c] += tree_lazy[nd];
			tree_min[c+1] += tree_lazy[nd];
			tree_lazy[c+1] += tree_lazy[nd];
			tree_lazy[nd] = 0;
		end
	endfunction

	function automatic void pull_min(int unsigned nd);
		if (2 * nd + 1 < NODES) tree_min[nd] = smin(tree_min[2*nd], tree_min[2*nd+1]);
	endfunction

	function automatic void tree_set(int unsigned nd, lo, hi, pos, bit [63:0] v);
		int unsigned mid;
		if (nd >= NODES) return;
		if (lo == hi) begin
			tree_min[nd] = v;
			return;
		end
		push_lazy(nd);
		mid = lo + (hi - lo) / 2;
		if (pos <= mid) tree_set(2*nd, lo, mid, pos, v);
		else tree_set(2*nd+1, mid+1, hi, pos, v);
		pull_min(nd);
	endfunction

	function automatic void tree_add(int unsigned nd, lo, hi, st, en, bit [63:0] d);
		int unsigned mid;
		if (nd >= NODES || hi < st || lo > en) return;
		if (st <= lo && hi <= en) begin
			tree_min[nd] += d;
			tree_lazy[nd] += d;
			return;
		end
		push_lazy(nd);
		mid = lo + (hi - lo) / 2;
		tree_add(2*nd, lo, mid, st, en, d);
		tree_add(2*nd+1, mid+1, hi, st, en, d);
		pull_min(nd);
	endfunction

	function automatic void tree_query(int unsigned nd, lo, hi, st, en,
			inout bit [63:0] best, inout bit found);
		int unsigned mid;
		if (nd >= NODES || hi < st || lo > en) return;
		if (st <= lo && hi <= en) begin
			best = found ? smin(best, tree_min[nd]) : tree_min[nd];
			found = 1;
			return;
		end
		push_lazy(nd);
		mid = lo + (hi - lo) / 2;
		tree_query(2*nd, lo, mid, st, en, best, found);
		tree_query(2*nd+1, mid+1, hi, st, en, best, found);
	endfunction

	function automatic void predict_item(crm_pkg::req_t it);
		int unsigned n, l, r;
		bit [63:0] d, best;
		bit found;
		crm_pkg::rsp_t res;
		n = (32'(size_reg) > 1024) ? 1024 : 32'(size_reg);
		l = 32'(it.left_index);
		r = 32'(it.right_index);
		d = {{32{it.data_value[31]}}, it.data_value};
		best = 0;
		found = 0;
		res = '0;
		if (it.req_type != crm_pkg::OP_LOAD && it.req_type != crm_pkg::OP_QUERY
				&& it.req_type != crm_pkg::OP_ADD) return;
		if (l >= n || (it.req_type != crm_pkg::OP_LOAD && r >= n)) begin
			res.index_error = 1'b1;
			expected_q = {expected_q, res};
			n_oob++;
			return;
		end
		case (it.req_type)
			crm_pkg::OP_LOAD: begin
				tree_set(1, 0, n - 1, l, d);
				n_loads++;
			end
			crm_pkg::OP_ADD: begin
				if (l <= r) tree_add(1, 0, n - 1, l, r, d);
				else begin
					tree_add(1, 0, n - 1, l, n - 1, d);
					tree_add(1, 0, n - 1, 0, r, d);
				end
				n_adds++;
			end
			default: begin
				if (l <= r) tree_query(1, 0, n - 1, l, r, best, found);
				else begin
					tree_query(1, 0, n - 1, l, n - 1, best, found);
					tree_query(1, 0, n - 1, 0, r, best, found);
				end
				res.min_value = best;
				expected_q = {expected_q, res};
				n_queries++;
			end
		endcase
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// request side: accept at posedge, drive at negedge
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			predict_item(req);
			beat_taken = 1;
		end
	end

	always @(negedge clk) begin
		if (!req_valid || beat_taken) begin
			beat_taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_q.size() > 0 && arst_n) begin
				req <= pending_q[0];
				pending_q.delete(0);
				req_valid <= 1'b1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end else
				req_valid <= 1'b0;
		end
	end

	// response side stall pattern
	always @(negedge clk) begin
		if (long_hold_req && hold_left == 0) begin
			long_hold_req = 0;
			hold_left = 6000;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 400);
				stall_mode = $urandom_range(0, 2);
			end
			mode_left--;
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rsp++;
			if (expected_q.size() == 0)
				report("unexpected beat", rsp.min_value, 64'(rsp.index_error));
			else begin
				crm_pkg::rsp_t want;
				want = expected_q[0];
				expected_q.delete(0);
				if (rsp.min_value !== want.min_value)
					report("min_value", rsp.min_value, want.min_value);
				if (rsp.index_error !== want.index_error)
					report("index_error", 64'(rsp.index_error), 64'(want.index_error));
			end
		end
	end

	function automatic crm_pkg::req_t mk(logic [1:0] op, int l, int r, logic [31:0] d);
		crm_pkg::req_t it;
		it.req_type = op;
		it.left_index = 10'(l);
		it.right_index = 10'(r);
		it.data_value = d;
		return it;
	endfunction

	function automatic logic [31:0] rand_data();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4, 5: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random(int count);
		int unsigned n, k;
		logic [1:0] op;
		n = (32'(size_reg) > 1024) ? 1024 : 32'(size_reg);
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (k < 4)
				put_item(mk(OP_UNUSED, $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom));
			else if (n == 0 || (k < 12 && n < 1024)) begin
				case ($urandom_range(0, 2))
					0: op = crm_pkg::OP_LOAD;
					1: op = crm_pkg::OP_QUERY;
					default: op = crm_pkg::OP_ADD;
				endcase
				if (n == 0 || $urandom_range(0, 1) == 0 || op == crm_pkg::OP_LOAD)
					put_item(mk(op, $urandom_range(n, 1023),
						$urandom_range(0, 1023), rand_data()));
				else
					put_item(mk(op, $urandom_range(0, n - 1),
						$urandom_range(n, 1023), rand_data()));
			end else begin
				op = (k < 25) ? crm_pkg::OP_LOAD : (k < 60) ? crm_pkg::OP_ADD : crm_pkg::OP_QUERY;
				put_item(mk(op, $urandom_range(0, n - 1),
					$urandom_range(0, n - 1), rand_data()));
			end
		end
	endtask

	task automatic load_all();
		int unsigned n;
		n = (32'(size_reg) > 1024) ? 1024 : 32'(size_reg);
		for (int i = 0; i < n; i++) put_item(mk(crm_pkg::OP_LOAD, i, 0, rand_data()));
	endtask

	task automatic load_some(int count);
		put_item(mk(crm_pkg::OP_LOAD, 1023, 0, rand_data()));
		repeat (count - 1)
			put_item(mk(crm_pkg::OP_LOAD, $urandom_range(0, 1023), 0, rand_data()));
	endtask

	task automatic drain();
		wait (pending_q.size() == 0);
		@(posedge clk);
		while (req_valid) @(posedge clk);
		wait (expected_q.size() == 0);
		repeat (2000) @(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic set_size(logic [10:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		size_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_size(11'd200);
		load_all();
		drain();

		put_item(mk(crm_pkg::OP_QUERY, 0, 199, 0));
		put_item(mk(crm_pkg::OP_QUERY, 199, 0, 0));
		put_item(mk(crm_pkg::OP_QUERY, 100, 99, 0));
		put_item(mk(crm_pkg::OP_ADD, 0, 199, 32'h7fff_ffff));
		put_item(mk(crm_pkg::OP_ADD, 190, 3, 32'h8000_0000));
		put_item(mk(crm_pkg::OP_QUERY, 0, 0, 0));
		put_item(mk(crm_pkg::OP_QUERY, 199, 199, 0));
		put_item(mk(crm_pkg::OP_LOAD, 5, 1023, 32'hffff_ffff));
		put_item(mk(crm_pkg::OP_QUERY, 4, 6, 0));
		put_item(mk(OP_UNUSED, 1023, 1023, 32'hffff_ffff));
		put_item(mk(crm_pkg::OP_ADD, 199, 199, 32'h1234_5678));
		put_item(mk(crm_pkg::OP_QUERY, 1, 0, 0));
		put_item(mk(crm_pkg::OP_QUERY, 199, 198, 0));
		add_random(100);
		drain();

		long_hold_req = 1;
		add_random(60);
		drain();

		set_size(11'd0);
		put_item(mk(crm_pkg::OP_LOAD, 0, 0, 32'h1));
		put_item(mk(crm_pkg::OP_QUERY, 0, 0, 0));
		put_item(mk(crm_pkg::OP_ADD, 0, 0, 32'h1));
		add_random(10);
		drain();

		set_size(11'd2047);
		load_some(20);
		drain();

		set_size(11'd1);
		load_all();
		add_random(30);
		drain();

		set_size(11'd2);
		load_all();
		add_random(30);
		drain();

		set_size(11'd13);
		load_all();
		put_item(mk(crm_pkg::OP_LOAD, 13, 0, 32'h5));
		put_item(mk(crm_pkg::OP_QUERY, 0, 1023, 0));
		put_item(mk(crm_pkg::OP_ADD, 1023, 0, 32'h5));
		add_random(60);
		drain();

		set_size(11'd37);
		load_all();
		add_random(40);
		drain();

		$display("Ran %0d loads, %0d adds, %0d queries, %0d index errors; %0d result beats.",
			n_loads, n_adds, n_queries, n_oob, n_rsp);
		$display("Array sizes 0, 1, 2, 13, 37, 200 and 2047 with random stalls on both sides.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#100ms;
		$display("Timeout");
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
sv/crm_pkg.sv
sv/crm_ram.sv
sv/crm_walk.sv
sv/circular_range_add_range_min_core.sv
sim/tb_top.sv
